FILE: rtl/core/adaptive_prediction_residual_mapper_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive prediction residual mapper
// Concurrent property shorthands shared by apm_mac and apm_predict.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_PREDICTION_RESIDUAL_MAPPER_UNIT_MACROS_SVH
`define ADAPTIVE_PREDICTION_RESIDUAL_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define APM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apm: next-cycle check failed");

`endif

FILE: rtl/core/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// Types and constants shared by the residual mapper modules.
// ----------------------------------------------------------------------------
package apm_pkg;

  localparam int SAMPLE_BITS          = 16;
  localparam int LOCAL_SUM_MID_FACTOR = 4;
  localparam int ACC_W                = 64;
  localparam int CFG_IDX_W            = 3;
  localparam int CFG_DATA_W           = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MAX        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MID        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RESOLUTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_SIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECEDING_BANDS   = 3'd5;

  localparam logic [6:0] REG_SIZE_MIN = 7'd32;
  localparam logic [6:0] REG_SIZE_MAX = 7'd64;

  typedef struct packed {
    logic [15:0] sample_min;
    logic [15:0] sample_max;
    logic [15:0] sample_mid;
    logic [4:0]  weight_resolution;
    logic [6:0]  register_size;
    logic [3:0]  preceding_bands;
  } apm_cfg_t;

  typedef struct packed {
    logic [15:0] current_sample;
    logic [15:0] prev_band_sample;
    logic        first_pixel;
    logic        first_band;
  } apm_pix_t;

  typedef struct packed {
    logic [18:0] diff_value;
    logic [21:0] weight_value;
    logic        term_valid;
    logic        last_term;
    logic [17:0] local_sum;
    apm_pix_t    pix;
  } apm_term_t;

  typedef struct packed {
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] offs;
    apm_pix_t         pix;
  } apm_sum_t;

  typedef struct packed {
    logic [16:0] scaled_prediction;
    logic [15:0] current_sample;
  } apm_pred_t;

endpackage

FILE: rtl/core/apm_mac.sv
// ----------------------------------------------------------------------------
// apm_mac
// Input register, weight-difference product and dot-product accumulator.
// ----------------------------------------------------------------------------
`include "adaptive_prediction_residual_mapper_unit_macros.svh"

module apm_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  apm_pkg::apm_cfg_t    cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  apm_pkg::apm_term_t   up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output apm_pkg::apm_sum_t    dn_data
);

  logic                      v0;
  apm_pkg::apm_term_t        t0;
  logic                      v1;
  logic [apm_pkg::ACC_W-1:0] s1_prod;
  logic [apm_pkg::ACC_W-1:0] s1_offs;
  logic                      s1_last;
  apm_pkg::apm_pix_t         s1_pix;
  logic                      v2;
  logic [apm_pkg::ACC_W-1:0] acc;

  logic                      rdy0;
  logic                      rdy1;
  logic                      rdy2;
  logic signed [40:0]        prod_full;
  logic [apm_pkg::ACC_W-1:0] prod_ext;
  logic [apm_pkg::ACC_W-1:0] offs_base;
  logic [apm_pkg::ACC_W-1:0] offs_next;
  logic [apm_pkg::ACC_W-1:0] acc_sum;

  assign rdy2     = !v2 || dn_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign up_ready = rdy0;
  assign dn_valid = v2;

  assign prod_full = $signed(t0.diff_value) * $signed(t0.weight_value);
  assign prod_ext  = t0.term_valid ? apm_pkg::ACC_W'(prod_full) : '0;
  assign offs_base = apm_pkg::ACC_W'(t0.local_sum)
                   - apm_pkg::ACC_W'(cfg.sample_mid)
                     * apm_pkg::ACC_W'(apm_pkg::LOCAL_SUM_MID_FACTOR);
  assign offs_next = offs_base << cfg.weight_resolution;
  assign acc_sum   = acc + s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      acc <= '0;
    end else begin
      if (rdy0) begin
        v0 <= up_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      // drop non-last transactions once their term is in the accumulator
      if (rdy2) begin
        v2 <= v1 && s1_last;
      end
      if (v1 && rdy2) begin
        acc <= s1_last ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy0) begin
      t0 <= up_data;
    end
    if (v0 && rdy1) begin
      s1_prod <= prod_ext;
      s1_offs <= offs_next;
      s1_last <= t0.last_term;
      s1_pix  <= t0.pix;
    end
    if (v1 && s1_last && rdy2) begin
      dn_data.dot  <= acc_sum;
      dn_data.offs <= s1_offs;
      dn_data.pix  <= s1_pix;
    end
  end

  `APM_ASSERT_NEXT(a_acc_clear, clk, rst, v1 && s1_last && rdy2, acc == '0)
  `APM_ASSERT_NEXT(a_sum_hold, clk, rst, v2 && !dn_ready, v2 && $stable(dn_data))

endmodule

FILE: rtl/core/apm_predict.sv
// ----------------------------------------------------------------------------
// apm_predict
// Offset add, modular wrap, arithmetic shift, mid offset, clipping and first-pixel selection.
// ----------------------------------------------------------------------------
`include "adaptive_prediction_residual_mapper_unit_macros.svh"

module apm_predict (
  input  logic                 clk,
  input  logic                 rst,
  input  apm_pkg::apm_cfg_t    cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  apm_pkg::apm_sum_t    up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output apm_pkg::apm_pred_t   dn_data
);

  logic                      v3;
  logic [apm_pkg::ACC_W-1:0] hp3;
  apm_pkg::apm_pix_t         pix3;
  logic                      v4;
  logic [apm_pkg::ACC_W-1:0] sh4;
  apm_pkg::apm_pix_t         pix4;
  logic                      v5;

  logic                      rdy3;
  logic                      rdy4;
  logic                      rdy5;
  logic [6:0]                r_eff;
  logic [5:0]                top_bit;
  logic [5:0]                shamt;
  logic [apm_pkg::ACC_W-1:0] wrapped;
  logic [apm_pkg::ACC_W-1:0] shifted;
  logic signed [63:0]        hr;
  logic signed [63:0]        lo64;
  logic signed [63:0]        hi64;
  logic signed [63:0]        clip_lo;
  logic signed [63:0]        clip_hi;
  logic [16:0]               lo17;
  logic [16:0]               hi17;
  logic [16:0]               sp_calc;
  logic [16:0]               sp_first;
  logic [16:0]               sp_next;

  assign rdy5     = !v5 || dn_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign up_ready = rdy3;
  assign dn_valid = v5;

  // stage 4: wrap to R bits, then shift by resolution plus one
  always_comb begin
    if (cfg.register_size < apm_pkg::REG_SIZE_MIN) begin
      r_eff = apm_pkg::REG_SIZE_MIN;
    end else if (cfg.register_size > apm_pkg::REG_SIZE_MAX) begin
      r_eff = apm_pkg::REG_SIZE_MAX;
    end else begin
      r_eff = cfg.register_size;
    end
    top_bit = 6'(r_eff - 7'd1);
    for (int i = 0; i < apm_pkg::ACC_W; i++) begin
      wrapped[i] = (7'(i) < r_eff) ? hp3[i] : hp3[top_bit];
    end
  end

  assign shamt   = {1'b0, cfg.weight_resolution} + 6'd1;
  assign shifted = $signed(wrapped) >>> shamt;

  // stage 5: add mid offset, clip, or take the first-pixel prediction
  assign lo17    = {cfg.sample_min, 1'b0};
  assign hi17    = {cfg.sample_max, 1'b1};
  assign lo64    = $signed(64'(lo17));
  assign hi64    = $signed(64'(hi17));
  assign hr      = $signed(sh4) + $signed(64'({cfg.sample_mid, 1'b1}));
  assign clip_lo = (hr < lo64) ? lo64 : hr;
  assign clip_hi = (clip_lo > hi64) ? hi64 : clip_lo;
  assign sp_calc = clip_hi[16:0];

  assign sp_first = (pix4.first_band || cfg.preceding_bands == 4'd0)
                  ? {cfg.sample_mid, 1'b0} : {pix4.prev_band_sample, 1'b0};
  assign sp_next  = pix4.first_pixel ? sp_first : sp_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy3) begin
        v3 <= up_valid;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy3) begin
      hp3  <= up_data.dot + up_data.offs;
      pix3 <= up_data.pix;
    end
    if (v3 && rdy4) begin
      sh4  <= shifted;
      pix4 <= pix3;
    end
    if (v4 && rdy5) begin
      dn_data.scaled_prediction <= sp_next;
      dn_data.current_sample    <= pix4.current_sample;
    end
  end

  `APM_ASSERT_IMPL(a_clip_range, clk, rst, v4 && cfg.sample_min <= cfg.sample_max, sp_calc >= lo17 && sp_calc <= hi17)

endmodule

FILE: rtl/core/apm_map.sv
// ----------------------------------------------------------------------------
// apm_map
// Maps the prediction residual and holds the result register.
// ----------------------------------------------------------------------------
module apm_map (
  input  logic                 clk,
  input  logic                 rst,
  input  apm_pkg::apm_cfg_t    cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  apm_pkg::apm_pred_t   up_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [16:0]          scaled_prediction,
  output logic [15:0]          mapped_residual
);

  logic                v6;
  logic                rdy6;
  logic [15:0]         pred;
  logic signed [18:0]  delta;
  logic signed [18:0]  t1;
  logic signed [18:0]  t2;
  logic signed [18:0]  omega;
  logic signed [18:0]  mag;
  logic signed [18:0]  res;
  logic                even;

  assign rdy6      = !v6 || !out_stall;
  assign up_ready  = rdy6;
  assign out_valid = v6;

  assign pred  = up_data.scaled_prediction[16:1];
  assign even  = !up_data.scaled_prediction[0];
  assign delta = $signed(19'(up_data.current_sample)) - $signed(19'(pred));
  assign t1    = $signed(19'(pred)) - $signed(19'(cfg.sample_min));
  assign t2    = $signed(19'(cfg.sample_max)) - $signed(19'(pred));
  assign omega = (t1 > t2) ? t2 : t1;
  assign mag   = (delta < 0) ? -delta : delta;

  always_comb begin
    if (mag > omega) begin
      res = mag + omega;
    end else if ((even && delta >= 0) || (!even && delta <= 0)) begin
      res = mag <<< 1;
    end else begin
      res = (mag <<< 1) - 19'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy6) begin
      scaled_prediction <= up_data.scaled_prediction;
      mapped_residual   <= res[15:0];
    end
  end

endmodule

FILE: rtl/core/adaptive_prediction_residual_mapper_unit.sv
// ----------------------------------------------------------------------------
// adaptive_prediction_residual_mapper_unit
// Dot-product accumulation, scaled prediction and residual mapping.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | sink      | in_valid / in_stall  | one weight/difference term + pixel info
// cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
// out     | source    | out_valid / out_stall| scaled_prediction, mapped_residual
//
// One transaction is taken per cycle while in_stall is low; the MAC sets it.
// After its last term is accepted, a pixel's result passes registers v0 to v6.
// Reset is synchronous; no clearing pass, the block is ready when reset falls.
// A stalled output fills the seven stage registers before in_stall rises.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module adaptive_prediction_residual_mapper_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [18:0]                     diff_value,
  input  logic [21:0]                     weight_value,
  input  logic                            term_valid,
  input  logic                            last_term,
  input  logic [17:0]                     local_sum,
  input  logic [15:0]                     current_sample,
  input  logic [15:0]                     prev_band_sample,
  input  logic                            first_pixel,
  input  logic                            first_band,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [16:0]                     scaled_prediction,
  output logic [15:0]                     mapped_residual
);

  localparam logic [15:0] MID_MASK = 16'((32'd1 << apm_pkg::SAMPLE_BITS) - 32'd1);

  logic [15:0]          sample_min;
  logic [15:0]          sample_max;
  logic [15:0]          sample_mid;
  logic [4:0]           weight_resolution;
  logic [6:0]           register_size;
  logic [3:0]           preceding_bands;

  apm_pkg::apm_cfg_t    cfg;
  apm_pkg::apm_term_t   term;
  apm_pkg::apm_sum_t    sum_data;
  apm_pkg::apm_pred_t   pred_data;
  logic                 mac_ready;
  logic                 sum_valid;
  logic                 sum_ready;
  logic                 pred_valid;
  logic                 pred_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_min        <= 16'd0;
      sample_max        <= 16'hFFFF;
      sample_mid        <= 16'h8000;
      weight_resolution <= 5'd13;
      register_size     <= 7'd64;
      preceding_bands   <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        apm_pkg::CFG_SAMPLE_MIN:        sample_min        <= cfg_data;
        apm_pkg::CFG_SAMPLE_MAX:        sample_max        <= cfg_data;
        apm_pkg::CFG_SAMPLE_MID:        sample_mid        <= cfg_data;
        apm_pkg::CFG_WEIGHT_RESOLUTION: weight_resolution <= cfg_data[4:0];
        apm_pkg::CFG_REGISTER_SIZE:     register_size     <= cfg_data[6:0];
        apm_pkg::CFG_PRECEDING_BANDS:   preceding_bands   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.sample_min        = sample_min;
    cfg.sample_max        = sample_max;
    cfg.sample_mid        = sample_mid & MID_MASK;
    cfg.weight_resolution = weight_resolution;
    cfg.register_size     = register_size;
    cfg.preceding_bands   = preceding_bands;
  end

  always_comb begin
    term.diff_value           = diff_value;
    term.weight_value         = weight_value;
    term.term_valid           = term_valid;
    term.last_term            = last_term;
    term.local_sum            = local_sum;
    term.pix.current_sample   = current_sample;
    term.pix.prev_band_sample = prev_band_sample;
    term.pix.first_pixel      = first_pixel;
    term.pix.first_band       = first_band;
  end

  assign in_stall = !mac_ready;

  apm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (mac_ready),
    .up_data  (term),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_data  (sum_data)
  );

  apm_predict u_predict (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_data  (sum_data),
    .dn_valid (pred_valid),
    .dn_ready (pred_ready),
    .dn_data  (pred_data)
  );

  apm_map u_map (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .up_valid          (pred_valid),
    .up_ready          (pred_ready),
    .up_data           (pred_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .scaled_prediction (scaled_prediction),
    .mapped_residual   (mapped_residual)
  );

endmodule
